/* hdl/position_history_ghost_interpolator_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the ghost interpolator
// Concurrent check helpers sampled on a clock with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef POSITION_HISTORY_GHOST_INTERPOLATOR_CORE_MACROS_SVH
`define POSITION_HISTORY_GHOST_INTERPOLATOR_CORE_MACROS_SVH

// Same-cycle implication
`define PHGI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define PHGI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/phgi_pkg.sv */
// ----------------------------------------------------------------------------
// phgi_pkg
// Shared types and codes for the position history ghost interpolator.
// ----------------------------------------------------------------------------
package phgi_pkg;

	// Operation codes of an input item
	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_GHOST_COUNT = 2'd0;
	localparam logic [1:0] REG_TRAIL       = 2'd1;
	localparam logic [1:0] REG_BASE_OPAC   = 2'd2;

	localparam int MAX_GHOSTS = 64;

	// Divider operand widths
	localparam int DIV_NW = 48;
	localparam int DIV_DW = 32;

	typedef struct packed {
		logic               operation;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [31:0]        time_us;
	} in_item_t;

	typedef struct packed {
		logic [5:0]         ghost_index;
		logic signed [15:0] ghost_x;
		logic signed [15:0] ghost_y;
		logic [7:0]         opacity;
		logic               last;
	} out_item_t;

	// One history entry as held in memory
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [31:0]        t;
	} hist_entry_t;

endpackage

/* hdl/phgi_div.sv */
// ----------------------------------------------------------------------------
// phgi_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module phgi_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [phgi_pkg::DIV_NW-1:0]   dividend,
	input  logic [phgi_pkg::DIV_DW-1:0]   divisor,
	output logic                          done,
	output logic [phgi_pkg::DIV_NW-1:0]   quotient
);
	import phgi_pkg::*;

	localparam int CW = $clog2(DIV_NW + 1);

	logic [DIV_NW-1:0] num_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW:0]   rem_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic [DIV_DW:0]   rem_sh;
	logic [DIV_DW:0]   rem_sub;
	logic              take;

	// Shift in the next dividend bit and trial-subtract
	always_comb begin
		rem_sh  = {rem_q[DIV_DW-1:0], num_q[DIV_NW-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		take    = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend register turns into the quotient
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? rem_sub : rem_sh;
			num_q <= {num_q[DIV_NW-2:0], take};
		end
	end

	assign quotient = num_q;

endmodule

/* hdl/phgi_hist_mem.sv */
// ----------------------------------------------------------------------------
// phgi_hist_mem
// History store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module phgi_hist_mem #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [ADDR_W-1:0]          waddr,
	input  phgi_pkg::hist_entry_t      wdata,
	input  logic [ADDR_W-1:0]          raddr,
	output phgi_pkg::hist_entry_t      rdata
);
	import phgi_pkg::*;

	hist_entry_t mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* hdl/position_history_ghost_interpolator_core.sv */
// ----------------------------------------------------------------------------
// position_history_ghost_interpolator_core
// Timestamped cursor history with linearly interpolated ghost trail output.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item): a record transaction is
//   written into the history ring in the cycle it is taken and gives no
//   result; the block is ready again the next cycle.
//   A query transaction produces ghost_count transactions (clamped to 1..64)
//   on the ghost channel (ghost_valid / ghost_stall / ghost), index 0 first,
//   last set on the final one. item_stall stays high until the last ghost
//   is taken. Each ghost may use a shared serial divider for its time
//   offset and opacity (when more than one ghost is asked for) and for
//   each of its two coordinates (when the target falls between two history
//   entries), plus a binary search of the history memory on its single
//   read port. A stalled ghost holds in its output registers until taken.
//   Reset empties the history (count and oldest pointer clear) and loads
//   the register defaults 8, 50000 and 255. Registers sit at byte addresses
//   0, 4 and 8 of the APB port and are to be written only while the block
//   is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "position_history_ghost_interpolator_core_macros.svh"

module position_history_ghost_interpolator_core #(
	parameter int HISTORY_DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  phgi_pkg::in_item_t    item,
	output logic                  ghost_valid,
	input  logic                  ghost_stall,
	output phgi_pkg::out_item_t   ghost
);
	import phgi_pkg::*;

	localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);

	// Sequencer codes
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_OFF  = 5'd1;
	localparam logic [4:0] S_OFFW = 5'd2;
	localparam logic [4:0] S_OPS  = 5'd3;
	localparam logic [4:0] S_OPW  = 5'd4;
	localparam logic [4:0] S_RDN  = 5'd5;
	localparam logic [4:0] S_NEWW = 5'd6;
	localparam logic [4:0] S_FST  = 5'd7;
	localparam logic [4:0] S_BS   = 5'd8;
	localparam logic [4:0] S_BSW  = 5'd9;
	localparam logic [4:0] S_SA   = 5'd10;
	localparam logic [4:0] S_SB   = 5'd11;
	localparam logic [4:0] S_MULX = 5'd12;
	localparam logic [4:0] S_DIVX = 5'd13;
	localparam logic [4:0] S_MULY = 5'd14;
	localparam logic [4:0] S_DIVY = 5'd15;
	localparam logic [4:0] S_OUT  = 5'd16;

	function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] base,
			input logic [SLOT_W-1:0] k);
		logic [SLOT_W:0] s;
		s = {1'b0, base} + {1'b0, k};
		if (s >= (SLOT_W+1)'(HISTORY_DEPTH))
			s = s - (SLOT_W+1)'(HISTORY_DEPTH);
		return s[SLOT_W-1:0];
	endfunction

	// Configuration registers
	logic [6:0]  ghost_count_q;
	logic [19:0] trail_q;
	logic [7:0]  base_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ghost_count_q <= 7'd8;
			trail_q       <= 20'd50000;
			base_q        <= 8'd255;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_GHOST_COUNT: ghost_count_q <= pwdata[6:0];
				REG_TRAIL:       trail_q       <= pwdata[19:0];
				REG_BASE_OPAC:   base_q        <= pwdata[7:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_GHOST_COUNT: prdata = {25'd0, ghost_count_q};
			REG_TRAIL:       prdata = {12'd0, trail_q};
			REG_BASE_OPAC:   prdata = {24'd0, base_q};
			default:         prdata = '0;
		endcase
	end

	// Sequencer and datapath registers
	logic [4:0]        state_q;
	logic [SLOT_W-1:0] oldest_q;
	logic [CNT_W-1:0]  count_q;
	logic [31:0]       t_q;
	logic [5:0]        nm1_q;
	logic [5:0]        i_q;
	logic [31:0]       target_q;
	logic [7:0]        opac_q;
	logic [SLOT_W-1:0] lo_q;
	logic [SLOT_W-1:0] hi_q;
	logic [SLOT_W-1:0] mid_q;
	hist_entry_t       a_q;
	hist_entry_t       b_q;
	logic [31:0]       elapsed_q;
	logic [31:0]       span_q;
	logic [15:0]       dxm_q;
	logic [15:0]       dym_q;
	logic              dxn_q;
	logic              dyn_q;
	logic signed [15:0] gx_q;
	logic signed [15:0] gy_q;

	logic              acc;
	logic              rec_acc;
	logic              qry_acc;
	logic [CNT_W-1:0]  cnt_m1;
	logic [SLOT_W-1:0] newest_slot;
	logic [SLOT_W-1:0] wslot;
	logic [SLOT_W-1:0] mid_c;
	logic [SLOT_W-1:0] lo_m1;
	logic [SLOT_W-1:0] raddr;
	hist_entry_t       rd;
	hist_entry_t       wentry;
	logic [6:0]        n_c;

	assign acc     = (state_q == S_IDLE) && item_valid;
	assign rec_acc = acc && (item.operation == OP_RECORD);
	assign qry_acc = acc && (item.operation == OP_QUERY);
	assign cnt_m1  = count_q - 1'b1;
	assign newest_slot = slot_of(oldest_q, cnt_m1[SLOT_W-1:0]);
	assign wslot   = (count_q < CNT_W'(HISTORY_DEPTH)) ?
		slot_of(oldest_q, count_q[SLOT_W-1:0]) : oldest_q;
	assign mid_c   = lo_q + ((hi_q - lo_q) >> 1);
	assign lo_m1   = lo_q - 1'b1;
	assign wentry  = '{x: item.pos_x, y: item.pos_y, t: item.time_us};

	// Clamp the ghost count to 1..64
	always_comb begin
		if (ghost_count_q == 7'd0)
			n_c = 7'd1;
		else if (ghost_count_q > 7'(MAX_GHOSTS))
			n_c = 7'(MAX_GHOSTS);
		else
			n_c = ghost_count_q;
	end

	// Pick the memory read address for the coming state
	always_comb begin
		case (state_q)
			S_RDN:   raddr = newest_slot;
			S_BS:    raddr = (lo_q < hi_q) ? slot_of(oldest_q, mid_c) : slot_of(oldest_q, lo_q);
			S_SA:    raddr = (lo_q == '0) ? oldest_q : slot_of(oldest_q, lo_m1);
			default: raddr = oldest_q;
		endcase
	end

	phgi_hist_mem #(
		.DEPTH  (HISTORY_DEPTH),
		.ADDR_W (SLOT_W)
	) u_mem (
		.clk   (clk),
		.we    (rec_acc),
		.waddr (wslot),
		.wdata (wentry),
		.raddr (raddr),
		.rdata (rd)
	);

	// Shared divider operands
	logic              div_start;
	logic [DIV_NW-1:0] div_num;
	logic [DIV_DW-1:0] div_den;
	logic              div_done;
	logic [DIV_NW-1:0] div_q;
	logic [25:0]       off_prod;
	logic [8:0]        opac_k;
	logic [8:0]        opac_d;
	logic [16:0]       opac_num;
	logic [47:0]       px;
	logic [47:0]       py;

	assign off_prod = i_q * trail_q;
	assign opac_k   = {3'd0, nm1_q} + {1'b0, i_q, 2'b00};
	assign opac_d   = 9'(nm1_q) * 9'd5;
	assign opac_num = base_q * opac_k;
	assign px       = dxm_q * elapsed_q;
	assign py       = dym_q * elapsed_q;

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (state_q)
			S_OFF: begin
				div_start = (nm1_q != 6'd0);
				div_num   = DIV_NW'(off_prod);
				div_den   = DIV_DW'(nm1_q);
			end
			S_OPS: begin
				div_start = 1'b1;
				div_num   = DIV_NW'(opac_num);
				div_den   = DIV_DW'(opac_d);
			end
			S_MULX: begin
				div_start = 1'b1;
				div_num   = px;
				div_den   = span_q;
			end
			S_MULY: begin
				div_start = 1'b1;
				div_num   = py;
				div_den   = span_q;
			end
			default: ;
		endcase
	end

	phgi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_q)
	);

	// Bracket-entry arithmetic, taken with the earlier entry on the read port
	logic [31:0]        off32;
	logic [31:0]        span_c;
	logic [31:0]        el_c;
	logic signed [16:0] dx_c;
	logic signed [16:0] dy_c;
	logic signed [16:0] qs;
	logic signed [16:0] gx_c;
	logic signed [16:0] gy_c;

	assign off32  = 32'(div_q[25:0]);
	assign span_c = a_q.t - rd.t;
	assign dx_c   = 17'(a_q.x) - 17'(rd.x);
	assign dy_c   = 17'(a_q.y) - 17'(rd.y);
	assign qs     = $signed(div_q[16:0]);
	assign gx_c   = 17'(b_q.x) + (dxn_q ? -qs : qs);
	assign gy_c   = 17'(b_q.y) + (dyn_q ? -qs : qs);

	always_comb begin
		if (target_q <= rd.t)
			el_c = '0;
		else if ((target_q - rd.t) > span_c)
			el_c = span_c;
		else
			el_c = target_q - rd.t;
	end

	// History pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			count_q  <= '0;
		end else if (rec_acc) begin
			if (count_q < CNT_W'(HISTORY_DEPTH))
				count_q <= count_q + 1'b1;
			else
				oldest_q <= slot_of(oldest_q, SLOT_W'(1));
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (qry_acc) state_q <= S_OFF;
				S_OFF:  state_q <= (nm1_q == 6'd0) ? S_RDN : S_OFFW;
				S_OFFW: if (div_done) state_q <= S_OPS;
				S_OPS:  state_q <= S_OPW;
				S_OPW:  if (div_done) state_q <= S_RDN;
				S_RDN:  state_q <= (count_q == '0) ? S_OUT : S_NEWW;
				S_NEWW: state_q <= (count_q == CNT_W'(1) || target_q >= rd.t) ? S_OUT : S_FST;
				S_FST:  state_q <= (target_q <= rd.t) ? S_OUT : S_BS;
				S_BS:   state_q <= (lo_q < hi_q) ? S_BSW : S_SA;
				S_BSW:  state_q <= S_BS;
				S_SA:   state_q <= S_SB;
				S_SB:   state_q <= (lo_q == '0 || a_q.t <= rd.t) ? S_OUT : S_MULX;
				S_MULX: state_q <= S_DIVX;
				S_DIVX: if (div_done) state_q <= S_MULY;
				S_MULY: state_q <= S_DIVY;
				S_DIVY: if (div_done) state_q <= S_OUT;
				S_OUT: begin
					if (!ghost_stall)
						state_q <= (i_q == nm1_q) ? S_IDLE : S_OFF;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (qry_acc) begin
					t_q   <= item.time_us;
					nm1_q <= 6'(n_c - 7'd1);
					i_q   <= '0;
				end
			end
			S_OFF: begin
				if (nm1_q == 6'd0) begin
					target_q <= (count_q != '0) ? 32'hFFFF_FFFF : t_q;
					opac_q   <= base_q;
				end
			end
			S_OFFW: if (div_done) target_q <= (off32 > t_q) ? 32'd0 : t_q - off32;
			S_OPW:  if (div_done) opac_q <= div_q[7:0];
			S_RDN: begin
				gx_q <= '0;
				gy_q <= '0;
			end
			S_NEWW: begin
				gx_q <= rd.x;
				gy_q <= rd.y;
			end
			S_FST: begin
				gx_q <= rd.x;
				gy_q <= rd.y;
				lo_q <= '0;
				hi_q <= cnt_m1[SLOT_W-1:0];
			end
			S_BS: mid_q <= mid_c;
			S_BSW: begin
				if (rd.t < target_q)
					lo_q <= mid_q + 1'b1;
				else
					hi_q <= mid_q;
			end
			S_SA: a_q <= rd;
			S_SB: begin
				b_q       <= rd;
				gx_q      <= rd.x;
				gy_q      <= rd.y;
				span_q    <= span_c;
				elapsed_q <= el_c;
				dxn_q     <= dx_c[16];
				dyn_q     <= dy_c[16];
				dxm_q     <= dx_c[16] ? 16'(-dx_c) : dx_c[15:0];
				dym_q     <= dy_c[16] ? 16'(-dy_c) : dy_c[15:0];
			end
			S_DIVX: if (div_done) gx_q <= gx_c[15:0];
			S_DIVY: if (div_done) gy_q <= gy_c[15:0];
			S_OUT:  if (!ghost_stall) i_q <= i_q + 1'b1;
			default: ;
		endcase
	end

	// Ghost output, held in registers while stalled
	assign item_stall  = (state_q != S_IDLE);
	assign ghost_valid = (state_q == S_OUT);
	assign ghost = '{ghost_index: i_q, ghost_x: gx_q, ghost_y: gy_q,
		opacity: opac_q, last: (i_q == nm1_q)};

	// Checks
	`PHGI_ASSERT_IMPL(a_busy_while_out, clk, arst_n, ghost_valid, item_stall, "input taken during output")
	`PHGI_ASSERT_NEXT(a_last_ends, clk, arst_n, ghost_valid && ghost.last && !ghost_stall, !ghost_valid, "ghost after last")
	`PHGI_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(HISTORY_DEPTH), "history count overflow")
	`PHGI_ASSERT_NEXT(a_rec_grow, clk, arst_n, rec_acc && (count_q < CNT_W'(HISTORY_DEPTH)), count_q == $past(count_q) + 1'b1, "record did not grow history")

endmodule

/* test/position_history_ghost_interpolator_core_test.sv */
// ----------------------------------------------------------------------------
// position_history_ghost_interpolator_core_test
// Drives record and query transactions with random idling on both channels,
// predicts every ghost from a local model of the history ring and checks
// each ghost transaction in order. Registers are set over APB between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module position_history_ghost_interpolator_core_test;
	import phgi_pkg::*;

	localparam int DEPTH = 64;
	localparam int WATCHDOG_LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid;
	logic        item_stall;
	in_item_t    item;
	logic        ghost_valid;
	logic        ghost_stall;
	out_item_t   ghost;

	// Local copy of the block's state
	logic signed [15:0] trk_x [DEPTH];
	logic signed [15:0] trk_y [DEPTH];
	logic [31:0]        trk_t [DEPTH];
	int unsigned        trk_oldest, trk_count;
	int unsigned        cfg_count, cfg_trail, cfg_base;
	logic [31:0]        now_us;

	out_item_t   pending_ghosts[$];
	int          mismatches;
	int          send_idle_pct, recv_idle_pct;
	int          hold_cycles;
	int          quiet_cycles;

	position_history_ghost_interpolator_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.ghost_valid(ghost_valid), .ghost_stall(ghost_stall), .ghost(ghost)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Interpolate the tracked history at one target time
	function automatic void sample_history(input logic [31:0] target,
			output logic signed [15:0] sx, output logic signed [15:0] sy);
		int unsigned first, newest, lo, hi, mid, sb, sa;
		longint span, elapsed, dx, dy;
		sx = '0;
		sy = '0;
		if (trk_count == 0) return;
		first  = trk_oldest;
		newest = (trk_oldest + trk_count - 1) % DEPTH;
		if (trk_count == 1 || target >= trk_t[newest]) begin
			sx = trk_x[newest];
			sy = trk_y[newest];
			return;
		end
		if (target <= trk_t[first]) begin
			sx = trk_x[first];
			sy = trk_y[first];
			return;
		end
		lo = 0;
		hi = trk_count - 1;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (trk_t[(trk_oldest + mid) % DEPTH] < target) lo = mid + 1;
			else hi = mid;
		end
		if (lo == 0) begin
			sx = trk_x[first];
			sy = trk_y[first];
			return;
		end
		sb = (trk_oldest + lo - 1) % DEPTH;
		sa = (trk_oldest + lo) % DEPTH;
		span = longint'(trk_t[sa]) - longint'(trk_t[sb]);
		if (span <= 0) begin
			sx = trk_x[sb];
			sy = trk_y[sb];
			return;
		end
		elapsed = longint'(target) - longint'(trk_t[sb]);
		if (elapsed < 0) elapsed = 0;
		if (elapsed > span) elapsed = span;
		dx = (longint'(trk_x[sa]) - longint'(trk_x[sb])) * elapsed / span;
		dy = (longint'(trk_y[sa]) - longint'(trk_y[sb])) * elapsed / span;
		sx = 16'(longint'(trk_x[sb]) + dx);
		sy = 16'(longint'(trk_y[sb]) + dy);
	endfunction

	// Update the history or queue the ghosts of a query
	task automatic predict_ghosts(input in_item_t it);
		int unsigned n, slot;
		longint unsigned off;
		logic [31:0] target;
		out_item_t g;
		if (it.operation == OP_RECORD) begin
			if (trk_count < DEPTH) begin
				slot = (trk_oldest + trk_count) % DEPTH;
				trk_count++;
			end else begin
				slot = trk_oldest;
				trk_oldest = (trk_oldest + 1) % DEPTH;
			end
			trk_x[slot] = it.pos_x;
			trk_y[slot] = it.pos_y;
			trk_t[slot] = it.time_us;
			return;
		end
		n = cfg_count;
		if (n == 0) n = 1;
		if (n > MAX_GHOSTS) n = MAX_GHOSTS;
		for (int unsigned i = 0; i < n; i++) begin
			g.ghost_index = 6'(i);
			g.last = (i + 1 == n);
			if (n == 1) begin
				target = (trk_count > 0) ? 32'hFFFF_FFFF : it.time_us;
				sample_history(target, g.ghost_x, g.ghost_y);
				g.opacity = 8'(cfg_base);
			end else begin
				off = longint'(i) * cfg_trail / (n - 1);
				target = (off > it.time_us) ? 32'd0 : 32'(it.time_us - off);
				sample_history(target, g.ghost_x, g.ghost_y);
				g.opacity = 8'((longint'(cfg_base) * ((n - 1) + 4 * i)) / (5 * (n - 1)));
			end
			pending_ghosts = {pending_ghosts, g};
		end
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		mismatches++;
	endtask

	// Send one transaction, honouring the sender idle rate
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		predict_ghosts(it);
		@(negedge clk);
	endtask

	task automatic send_record(input logic [31:0] t, input logic signed [15:0] x,
			input logic signed [15:0] y);
		in_item_t it;
		it.operation = OP_RECORD;
		it.pos_x = x;
		it.pos_y = y;
		it.time_us = t;
		send_item(it);
	endtask

	task automatic send_query(input logic [31:0] t);
		in_item_t it;
		it.operation = OP_QUERY;
		it.pos_x = 16'($urandom);
		it.pos_y = 16'($urandom);
		it.time_us = t;
		send_item(it);
	endtask

	// Write a register once the block has drained
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		item_valid <= 1'b0;
		while (pending_ghosts.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_GHOST_COUNT: cfg_count = value & 32'h7F;
			REG_TRAIL:       cfg_trail = value & 32'hFFFFF;
			default:         cfg_base  = value & 32'hFF;
		endcase
	endtask

	task automatic set_config(input int unsigned n, input int unsigned trail,
			input int unsigned base);
		write_reg(REG_GHOST_COUNT, n);
		write_reg(REG_TRAIL, trail);
		write_reg(REG_BASE_OPAC, base);
	endtask

	// Extremes of the fields and special cases
	task automatic test_directed();
		send_query(32'd1000);
		send_record(32'd100, 16'sh7FFF, -16'sh8000);
		send_query(32'd0);
		send_query(32'd100);
		send_record(32'd200, -16'sh8000, 16'sh7FFF);
		send_query(32'd150);
		send_query(32'd60000);
		send_record(32'd200, 16'sh0000, 16'sh0000);
		send_query(32'd200);
		send_record(32'd50000, 16'sh1234, -16'sh1234);
		send_query(32'd30000);
		send_query(32'hFFFF_FFFF);
		set_config(1, 0, 0);
		send_query(32'd25000);
		set_config(0, 1000000, 128);
		send_query(32'd40000);
		set_config(127, 1000000, 255);
		send_query(32'hFFFF_FFFF);
		set_config(64, 0, 255);
		send_query(32'd50000);
		set_config(2, 1, 1);
		send_query(32'd201);
	endtask

	// Records at rising times with random positions, mixed with queries mostly near the latest time
	task automatic test_random(input int items);
		for (int k = 0; k < items; k++) begin
			if ($urandom_range(99) < 70) begin
				now_us = now_us + $urandom_range(3000);
				send_record(now_us, 16'($urandom), 16'($urandom));
			end else if ($urandom_range(9) == 0) begin
				send_query($urandom);
			end else begin
				send_query(now_us + $urandom_range(2000));
			end
		end
	endtask

	// Hold the ghost channel off for a long stretch during a burst of queries
	task automatic test_backpressure();
		hold_cycles = 400;
		for (int k = 0; k < 4; k++) send_query(now_us + 10 * k);
	endtask

	// Ghost channel: stall at random and check every accepted transaction
	initial begin
		ghost_stall = 1'b1;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				ghost_stall <= 1'b1;
			end else begin
				ghost_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && ghost_valid && !ghost_stall) begin
			if (pending_ghosts.size() == 0) begin
				report_mismatch("unexpected ghost_index", ghost.ghost_index, 0);
			end else begin
				want = pending_ghosts.pop_front();
				if (ghost.ghost_index != want.ghost_index)
					report_mismatch("ghost_index", ghost.ghost_index, want.ghost_index);
				if (ghost.ghost_x != want.ghost_x)
					report_mismatch("ghost_x", 16'(ghost.ghost_x), 16'(want.ghost_x));
				if (ghost.ghost_y != want.ghost_y)
					report_mismatch("ghost_y", 16'(ghost.ghost_y), 16'(want.ghost_y));
				if (ghost.opacity != want.opacity)
					report_mismatch("opacity", ghost.opacity, want.opacity);
				if (ghost.last != want.last)
					report_mismatch("last", ghost.last, want.last);
			end
		end
	end

	// Watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (ghost_valid && !ghost_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("position_history_ghost_interpolator_core verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		item = '0;
		mismatches = 0;
		quiet_cycles = 0;
		hold_cycles = 0;
		trk_oldest = 0;
		trk_count = 0;
		cfg_count = 8;
		cfg_trail = 50000;
		cfg_base = 255;
		now_us = 32'd60000;
		send_idle_pct = 11;
		recv_idle_pct = 69;
		for (int i = 0; i < DEPTH; i++) begin
			trk_x[i] = '0;
			trk_y[i] = '0;
			trk_t[i] = '0;
		end
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		set_config(4, 5000, 200);
		test_random(30);
		send_idle_pct = 69;
		recv_idle_pct = 11;
		set_config(16, 20000, 77);
		test_random(30);
		test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_config(6, 3000, 255);
		test_random(30);

		item_valid <= 1'b0;
		while (pending_ghosts.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		if (mismatches == 0) begin
			$display("position_history_ghost_interpolator_core verification clean");
		end else begin
			$display("position_history_ghost_interpolator_core verification failed");
		end
		$finish;
	end

endmodule
